FILE: rtl/dnp_pkg.sv
// dnp_pkg: shared types, character codes and header word tables for the
// data notice parser. No dependencies; imported by every rtl module.
package dnp_pkg;

  localparam int unsigned LenBits = 16;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  localparam logic [3:0] IdleLimitReset = 4'd3;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpC   = 8'h43;

  localparam logic [2:0] ClosedLen = 3'd6;
  localparam logic [3:0] NoticeLen = 4'd4;
  localparam logic [3:0] QueryLen  = 4'd11;

  typedef enum logic [1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_BYTE    = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_DATA  = 3'd1,
    ST_END   = 3'd2,
    ST_BAD   = 3'd3,
    ST_QUERY = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } item_t;

  // "CLOSED"
  function automatic logic [7:0] closed_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0: c = 8'h43;
      3'd1: c = 8'h4C;
      3'd2: c = 8'h4F;
      3'd3: c = 8'h53;
      3'd4: c = 8'h45;
      3'd5: c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "IPD,"
  function automatic logic [7:0] notice_char(input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      2'd0: c = 8'h49;
      2'd1: c = 8'h50;
      2'd2: c = 8'h44;
      2'd3: c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "CIPRECVLEN:"
  function automatic logic [7:0] query_char(input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      4'd0:  c = 8'h43;
      4'd1:  c = 8'h49;
      4'd2:  c = 8'h50;
      4'd3:  c = 8'h52;
      4'd4:  c = 8'h45;
      4'd5:  c = 8'h43;
      4'd6:  c = 8'h56;
      4'd7:  c = 8'h4C;
      4'd8:  c = 8'h45;
      4'd9:  c = 8'h4E;
      4'd10: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/dnp_parser.sv
// dnp_parser: parse state machine and result register, one word per cycle
// unless a full result register is stalled by the sink. Depends on dnp_pkg.
module dnp_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  dnp_pkg::item_t          item_i,
  input  logic [3:0]              idle_limit_i,
  output logic                    item_take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic [dnp_pkg::LenBits-1:0] length_o
);
  import dnp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HUNT  = 3'd1,
    PH_NHDR  = 3'd2,
    PH_NVAL  = 3'd3,
    PH_QPLUS = 3'd4,
    PH_QHDR  = 3'd5,
    PH_QVAL  = 3'd6
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           header_index_q, header_index_d;
  logic [2:0]           closed_index_q, closed_index_d;
  logic [LenBits-1:0]   value_acc_q, value_acc_d;
  logic [3:0]           idle_run_q, idle_run_d;
  logic                 closed_latch_q, closed_latch_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [LenBits-1:0]   length_q, length_d;

  logic                 res_valid;
  status_e              res_status;
  logic [LenBits-1:0]   res_length;
  logic                 is_digit;
  logic [LenBits+3:0]   acc_wide;
  logic [LenBits-1:0]   acc_digit;
  logic [4:0]           run_inc;
  logic [7:0]           c;

  assign c        = item_i.rx_byte;
  assign is_digit = (c >= CharZero) && (c <= CharNine);
  // acc*10 + digit, saturating
  assign acc_wide = {1'b0, value_acc_q, 3'b000} + {3'b000, value_acc_q, 1'b0}
                  + {{LenBits{1'b0}}, c[3:0]};
  assign acc_digit = (acc_wide > {4'b0000, LenMax}) ? LenMax : acc_wide[LenBits-1:0];
  assign run_inc  = {1'b0, idle_run_q} + 5'd1;

  assign item_take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d        = phase_q;
    header_index_d = header_index_q;
    closed_index_d = closed_index_q;
    value_acc_d    = value_acc_q;
    idle_run_d     = idle_run_q;
    closed_latch_d = closed_latch_q;
    res_valid      = 1'b0;
    res_status     = ST_NONE;
    res_length     = '0;

    case (item_i.func)
      FUNC_BEGIN: begin
        if (closed_latch_q) begin
          closed_latch_d = 1'b0;
          idle_run_d     = '0;
          phase_d        = PH_IDLE;
          res_valid      = 1'b1;
          res_status     = ST_END;
        end else begin
          phase_d        = PH_HUNT;
          closed_index_d = '0;
          header_index_d = '0;
        end
      end
      FUNC_BYTE: begin
        unique case (phase_q)
          PH_HUNT: begin
            if (c == CharPlus) begin
              phase_d        = PH_NHDR;
              header_index_d = '0;
            end else if (closed_index_q < ClosedLen && c == closed_char(closed_index_q)) begin
              if (closed_index_q + 3'd1 == ClosedLen) begin
                closed_index_d = '0;
                phase_d        = PH_QPLUS;
                res_valid      = 1'b1;
                res_status     = ST_QUERY;
              end else begin
                closed_index_d = closed_index_q + 3'd1;
              end
            end else begin
              closed_index_d = (c == CharUpC) ? 3'd1 : 3'd0;
            end
          end
          PH_NHDR: begin
            if (header_index_q < NoticeLen && c == notice_char(header_index_q[1:0])) begin
              header_index_d = header_index_q + 4'd1;
              if (header_index_q + 4'd1 == NoticeLen) begin
                phase_d     = PH_NVAL;
                value_acc_d = '0;
              end
            end else begin
              phase_d    = PH_IDLE;
              res_valid  = 1'b1;
              res_status = ST_BAD;
            end
          end
          PH_NVAL: begin
            if (c == CharCr || c == CharLf) begin
              phase_d    = PH_IDLE;
              idle_run_d = '0;
              res_valid  = 1'b1;
              res_status = ST_DATA;
              res_length = value_acc_q;
            end else if (is_digit) begin
              value_acc_d = acc_digit;
            end else if (c == CharComma) begin
              value_acc_d = '0;   // that was the link number
            end else begin
              phase_d    = PH_IDLE;
              res_valid  = 1'b1;
              res_status = ST_BAD;
            end
          end
          PH_QPLUS: begin
            if (c == CharPlus) begin
              phase_d        = PH_QHDR;
              header_index_d = '0;
            end
          end
          PH_QHDR: begin
            if (header_index_q < QueryLen && c == query_char(header_index_q)) begin
              header_index_d = header_index_q + 4'd1;
              if (header_index_q + 4'd1 == QueryLen) begin
                phase_d     = PH_QVAL;
                value_acc_d = '0;
              end
            end else begin
              closed_latch_d = 1'b1;
              phase_d        = PH_IDLE;
              res_valid      = 1'b1;
              res_status     = ST_END;
            end
          end
          PH_QVAL: begin
            if (is_digit) begin
              value_acc_d = acc_digit;
            end else if (value_acc_q != '0) begin
              phase_d    = PH_IDLE;
              idle_run_d = '0;
              res_valid  = 1'b1;
              res_status = ST_DATA;
              res_length = value_acc_q;
            end else begin
              closed_latch_d = 1'b1;
              phase_d        = PH_IDLE;
              res_valid      = 1'b1;
              res_status     = ST_END;
            end
          end
          default: ;
        endcase
      end
      FUNC_TIMEOUT: begin
        unique case (phase_q)
          PH_HUNT: begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            if (run_inc >= {1'b0, idle_limit_i}) begin
              idle_run_d = '0;
              res_status = ST_END;
            end else begin
              idle_run_d = run_inc[3:0];
              res_status = ST_NONE;
            end
          end
          PH_NHDR, PH_NVAL: begin
            phase_d    = PH_IDLE;
            res_valid  = 1'b1;
            res_status = ST_BAD;
          end
          PH_QPLUS, PH_QHDR, PH_QVAL: begin
            closed_latch_d = 1'b1;
            phase_d        = PH_IDLE;
            res_valid      = 1'b1;
            res_status     = ST_END;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result register: load on take, drain when the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    length_d    = length_q;
    if (item_take_o) begin
      out_valid_d = res_valid;
      status_d    = res_status;
      length_d    = res_length;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      header_index_q <= '0;
      closed_index_q <= '0;
      value_acc_q    <= '0;
      idle_run_q     <= '0;
      closed_latch_q <= 1'b0;
      out_valid_q    <= 1'b0;
      status_q       <= ST_NONE;
      length_q       <= '0;
    end else begin
      if (item_take_o) begin
        phase_q        <= phase_d;
        header_index_q <= header_index_d;
        closed_index_q <= closed_index_d;
        value_acc_q    <= value_acc_d;
        idle_run_q     <= idle_run_d;
        closed_latch_q <= closed_latch_d;
      end
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      length_q    <= length_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign length_o    = length_q;

  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_latch_q |-> (phase_q == PH_IDLE))
    else $error("closed latch set outside idle phase");

  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !item_take_o)
    else $error("item taken while result register is blocked");

  a_len_zero_nondata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_DATA) |-> (length_q == '0))
    else $error("nonzero length on a non-data result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (header_index_q <= QueryLen) && (closed_index_q < ClosedLen) && (idle_run_q != 4'd15))
    else $error("parse index or idle run out of range");

endmodule

FILE: rtl/data_notice_parser_core.sv
// A word is first captured in the input register, then parsed, and its result is
// loaded into the output register, from which the sink takes it.
// Throughput: one word per cycle; the input register and the result register
// decouple the two sides, so the input stalls only while the output is stalled
// and full. Reset (rst_ni, async, active low) empties both registers, clears the
// parse state and loads idle_limit with 3.
module data_notice_parser_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [dnp_pkg::LenBits-1:0] length_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [3:0]                  cfg_data_i
);
  import dnp_pkg::*;

  logic       in_valid_q, in_valid_d;
  item_t      item_q, item_d;
  logic [3:0] idle_limit_q, idle_limit_d;
  logic       item_take;

  assign cfg_ready_o  = 1'b1;
  assign idle_limit_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : idle_limit_q;

  assign in_stall_o = in_valid_q && !item_take;

  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d.func    = func_i;
        item_d.rx_byte = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      idle_limit_q <= IdleLimitReset;
    end else begin
      in_valid_q   <= in_valid_d;
      idle_limit_q <= idle_limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  dnp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .idle_limit_i (idle_limit_q),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .length_o     (length_o)
  );

endmodule
